/* rtl/core/rsgf_pkg.sv */
// ----------------------------------------------------------------------------
// Residue score smoother package
// Shared types, constants and field layouts for the gap filler and smoother.
// ----------------------------------------------------------------------------
package rsgf_pkg;

	localparam int MAX_WINDOW  = 16;
	localparam int STORE_DEPTH = 34;
	localparam int SHED_LIMIT  = STORE_DEPTH - 2;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int WIN_W       = 5;
	localparam int SCORE_W     = 20;
	localparam int AREA_W      = 24;
	localparam int FRAC_W      = 16;
	localparam int SUM_W       = SCORE_W + CNT_W;
	localparam int DVD_W       = AREA_W + FRAC_W;
	localparam int DVS_W       = AREA_W;
	localparam int STEP_W      = $clog2(DVD_W + 1);

	localparam logic [1:0] KIND_SCORE = 2'd0;
	localparam logic [1:0] KIND_NOVAL = 2'd1;
	localparam logic [1:0] KIND_GAP   = 2'd2;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

	typedef struct packed {
		logic [7:0]         chain;
		logic [15:0]        num;
		logic [15:0]        len;
		logic [1:0]         kind;
		logic [SCORE_W-1:0] score;
	} entry_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* rtl/core/rsgf_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsgf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/core/rsgf_div.sv */
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division, one quotient bit per cycle, shared by ratio and mean.
// ----------------------------------------------------------------------------
module rsgf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  rsgf_pkg::div_req_t req,
	output rsgf_pkg::div_rsp_t rsp
);

	logic [rsgf_pkg::DVD_W-1:0]  dvd_q;
	logic [rsgf_pkg::DVS_W-1:0]  rem_q;
	logic [rsgf_pkg::DVS_W-1:0]  dvs_q;
	logic [rsgf_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;
	logic                        done_q;
	logic [rsgf_pkg::DVS_W:0]    shifted;
	logic                        fits;
	logic                        last_step;

	assign shifted   = {rem_q, dvd_q[rsgf_pkg::DVD_W-1]};
	assign fits      = shifted >= {1'b0, dvs_q};
	assign last_step = step_q == rsgf_pkg::STEP_W'(rsgf_pkg::DVD_W - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !req.start && last_step;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rsgf_pkg::DVS_W'(shifted - {1'b0, dvs_q}) :
				shifted[rsgf_pkg::DVS_W-1:0];
			dvd_q <= {dvd_q[rsgf_pkg::DVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dvd_q;

endmodule

/* rtl/core/residue_score_gap_fill_window_smoother.sv */
// ----------------------------------------------------------------------------
// Residue score gap filler and window smoother
// Sequencer over an entry store, a shared divider and an output register.
// ----------------------------------------------------------------------------
// Residues enter on the input channel (in_valid, in_stall), sorted by chain
// and number. Results leave on the output channel (out_valid, out_stall) in
// stream order: one per residue, plus one run item for each gap of missing
// numbers. The window register is written through cfg_wdata whenever cfg_we is
// high; the user writes it only while the block is idle, which the block itself does not enforce.
// The block works on one residue at a time and holds in_stall high while it
// does. An item runs the ratio division and the store writes; then, for each
// result emitted with a positive score and a nonzero window, a window sum over
// the stored entries and the mean division; then, unless the item is final,
// compaction of the store. The single divider and the one-read RAM port
// serialise this work.
// Results leave once their right-hand context is in or when a full store sheds
// them, and all of them leave on the final item, the last one flagged with last_out.
// A stall on the output holds the result register and pauses the sequencer
// only when it has a further result to hand over. Reset clears all control
// state and the window register; the entry store needs no clearing.
// ----------------------------------------------------------------------------
module residue_score_gap_fill_window_smoother (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rsgf_pkg::WIN_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    chain,
	input  logic signed [15:0]            residue_num,
	input  logic [rsgf_pkg::AREA_W-1:0]   ref_area,
	input  logic [rsgf_pkg::AREA_W-1:0]   diff_area,
	input  logic                          final_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_chain,
	output logic signed [15:0]            first_num,
	output logic [15:0]                   run_len,
	output logic [1:0]                    kind,
	output logic [rsgf_pkg::SCORE_W-1:0]  score,
	output logic                          last_out
);

	typedef enum logic [4:0] {
		S_IDLE, S_GAP, S_RATIO, S_RDY_A, S_RDY_D, S_EMIT, S_SUM_A, S_SUM_D,
		S_MEAN, S_OUT, S_POST, S_CMP_HEAD, S_CMP_HD, S_CMP_A, S_CMP_D,
		S_SHED, S_SHED_D, S_DROP_A, S_DROP_D
	} state_t;

	state_t                          state_q;
	logic [rsgf_pkg::WIN_W-1:0]      window_q;
	logic [rsgf_pkg::CNT_W-1:0]      count_q;
	logic [rsgf_pkg::CNT_W-1:0]      pend_q;
	logic [rsgf_pkg::CNT_W-1:0]      idx_q;
	logic [rsgf_pkg::CNT_W-1:0]      wr_q;
	logic [7:0]                      prev_chain_q;
	logic [15:0]                     prev_num_q;
	logic                            have_prev_q;
	logic [7:0]                      cur_chain_q;
	logic [15:0]                     cur_num_q;
	logic                            cur_ref_nz_q;
	logic                            fin_q;
	logic                            gap_q;
	logic [15:0]                     gap_len_q;
	rsgf_pkg::entry_t                e_q;
	logic                            ret_shed_q;
	logic [rsgf_pkg::SUM_W-1:0]      sum_q;
	logic [rsgf_pkg::CNT_W-1:0]      cnt_q;
	logic [rsgf_pkg::SCORE_W-1:0]    res_score_q;
	logic [7:0]                      fchain_q;
	logic signed [18:0]              fnum_q;
	logic                            div_start_q;
	logic [rsgf_pkg::DVD_W-1:0]      div_dvd_q;
	logic [rsgf_pkg::DVS_W-1:0]      div_dvs_q;
	logic                            out_valid_q;
	rsgf_pkg::entry_t                out_e_q;
	logic                            out_last_q;

	rsgf_pkg::div_req_t              div_req;
	rsgf_pkg::div_rsp_t              div_rsp;

	logic                            ram_we;
	logic [rsgf_pkg::ADDR_W-1:0]     ram_waddr;
	rsgf_pkg::entry_t                ram_wdata;
	logic [rsgf_pkg::ADDR_W-1:0]     ram_raddr;
	rsgf_pkg::entry_t                ram_rdata;

	logic [rsgf_pkg::WIN_W-1:0]      w_eff;
	logic [rsgf_pkg::CNT_W-1:0]      done_idx;
	logic [rsgf_pkg::CNT_W-1:0]      idx_nx;
	logic signed [16:0]              in_step;
	logic signed [16:0]              w_s17;
	logic signed [16:0]              num_delta;
	logic signed [18:0]              fdist;
	logic signed [17:0]              ready_lim;
	logic                            rd_pos;
	logic                            rdy_now;
	logic                            keep_now;
	logic                            match_now;
	logic [rsgf_pkg::SUM_W-1:0]      sum_nx;
	logic [rsgf_pkg::CNT_W-1:0]      cnt_nx;
	logic [rsgf_pkg::SCORE_W-1:0]    ratio_score;
	logic                            ratio_ok;
	logic                            out_free;

	assign w_eff = (int'(window_q) > rsgf_pkg::MAX_WINDOW) ?
		rsgf_pkg::WIN_W'(rsgf_pkg::MAX_WINDOW) : window_q;
	assign done_idx = count_q - pend_q;
	assign idx_nx   = idx_q + 1'b1;
	assign in_step  = {residue_num[15], residue_num} - {prev_num_q[15], prev_num_q};
	assign w_s17    = $signed({12'b0, w_eff});

	assign rd_pos = (ram_rdata.kind == rsgf_pkg::KIND_SCORE) && (ram_rdata.score != '0);
	assign ready_lim = $signed({{2{ram_rdata.num[15]}}, ram_rdata.num}) +
		$signed({13'b0, w_eff});
	assign rdy_now = fin_q || !rd_pos || (w_eff == '0) || (cur_chain_q != ram_rdata.chain) ||
		($signed({{2{cur_num_q[15]}}, cur_num_q}) >= ready_lim);

	assign fdist = fnum_q - $signed({{3{ram_rdata.num[15]}}, ram_rdata.num});
	assign keep_now = (idx_q >= done_idx) || ((w_eff != '0) && rd_pos &&
		(ram_rdata.chain == fchain_q) && (fdist <= $signed({14'b0, w_eff})));

	assign num_delta = $signed({ram_rdata.num[15], ram_rdata.num}) -
		$signed({e_q.num[15], e_q.num});
	assign match_now = rd_pos && (ram_rdata.chain == e_q.chain) &&
		(num_delta >= -w_s17) && (num_delta <= w_s17);
	assign sum_nx = match_now ? sum_q + rsgf_pkg::SUM_W'(ram_rdata.score) : sum_q;
	assign cnt_nx = match_now ? cnt_q + 1'b1 : cnt_q;

	assign ratio_score = (div_rsp.quotient[rsgf_pkg::DVD_W-1:rsgf_pkg::SCORE_W] != '0) ?
		rsgf_pkg::SCORE_MAX : div_rsp.quotient[rsgf_pkg::SCORE_W-1:0];
	assign ratio_ok = !cur_ref_nz_q || div_rsp.done;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[rsgf_pkg::ADDR_W-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[rsgf_pkg::ADDR_W-1:0];
		case (state_q)
			S_GAP: begin
				ram_we    = gap_q;
				ram_wdata = '{chain: cur_chain_q, num: prev_num_q + 16'd1, len: gap_len_q,
					kind: rsgf_pkg::KIND_GAP, score: '0};
			end
			S_RATIO: begin
				ram_we    = ratio_ok;
				ram_wdata = '{chain: cur_chain_q, num: cur_num_q, len: 16'd1,
					kind: cur_ref_nz_q ? rsgf_pkg::KIND_SCORE : rsgf_pkg::KIND_NOVAL,
					score: cur_ref_nz_q ? ratio_score : '0};
			end
			S_RDY_A, S_CMP_HEAD: begin
				ram_raddr = done_idx[rsgf_pkg::ADDR_W-1:0];
			end
			S_CMP_D: begin
				ram_we    = keep_now;
				ram_waddr = wr_q[rsgf_pkg::ADDR_W-1:0];
			end
			S_SHED: begin
				ram_raddr = '0;
			end
			S_DROP_D: begin
				ram_we    = 1'b1;
				ram_waddr = rsgf_pkg::ADDR_W'(idx_q - 1'b1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			window_q     <= '0;
			count_q      <= '0;
			pend_q       <= '0;
			prev_chain_q <= '0;
			prev_num_q   <= '0;
			have_prev_q  <= 1'b0;
			div_start_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			idx_q        <= '0;
			wr_q         <= '0;
			ret_shed_q   <= 1'b0;
		end else begin
			div_start_q <= ((state_q == S_IDLE) && in_valid && (ref_area != '0)) ||
				((state_q == S_SUM_D) && (idx_nx == count_q));
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall && !((state_q == S_OUT) && out_free)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cur_chain_q  <= chain;
						cur_num_q    <= residue_num;
						cur_ref_nz_q <= ref_area != '0;
						fin_q        <= final_item;
						gap_q        <= have_prev_q && (chain == prev_chain_q) &&
							(in_step > 17'sd1);
						gap_len_q    <= 16'(in_step - 17'sd1);
						div_dvd_q    <= {diff_area, rsgf_pkg::FRAC_W'(0)};
						div_dvs_q    <= ref_area;
						state_q      <= S_GAP;
					end
				end
				S_GAP: begin
					if (gap_q) begin
						count_q <= count_q + 1'b1;
						pend_q  <= pend_q + 1'b1;
					end
					state_q <= S_RATIO;
				end
				S_RATIO: begin
					if (ratio_ok) begin
						count_q      <= count_q + 1'b1;
						pend_q       <= pend_q + 1'b1;
						have_prev_q  <= 1'b1;
						prev_chain_q <= cur_chain_q;
						prev_num_q   <= cur_num_q;
						state_q      <= S_RDY_A;
					end
				end
				S_RDY_A: begin
					idx_q   <= done_idx;
					state_q <= (pend_q == '0) ? S_POST : S_RDY_D;
				end
				S_RDY_D: begin
					e_q        <= ram_rdata;
					ret_shed_q <= 1'b0;
					state_q    <= rdy_now ? S_EMIT : S_POST;
				end
				S_EMIT: begin
					if ((e_q.kind == rsgf_pkg::KIND_SCORE) && (e_q.score != '0) &&
						(w_eff != '0)) begin
						idx_q   <= '0;
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_SUM_A;
					end else begin
						res_score_q <= (e_q.kind == rsgf_pkg::KIND_SCORE) ? e_q.score : '0;
						state_q     <= S_OUT;
					end
				end
				S_SUM_A: begin
					state_q <= S_SUM_D;
				end
				S_SUM_D: begin
					sum_q <= sum_nx;
					cnt_q <= cnt_nx;
					idx_q <= idx_nx;
					if (idx_nx == count_q) begin
						div_dvd_q   <= rsgf_pkg::DVD_W'(sum_nx);
						div_dvs_q   <= rsgf_pkg::DVS_W'(cnt_nx);
						state_q     <= S_MEAN;
					end else begin
						state_q <= S_SUM_A;
					end
				end
				S_MEAN: begin
					if (div_rsp.done) begin
						res_score_q <= div_rsp.quotient[rsgf_pkg::SCORE_W-1:0];
						state_q     <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_e_q     <= '{chain: e_q.chain, num: e_q.num, len: e_q.len,
							kind: e_q.kind, score: res_score_q};
						out_last_q  <= fin_q && (pend_q == rsgf_pkg::CNT_W'(1));
						pend_q      <= pend_q - 1'b1;
						idx_q       <= rsgf_pkg::CNT_W'(1);
						state_q     <= ret_shed_q ? S_DROP_A : S_RDY_A;
					end
				end
				S_POST: begin
					if (fin_q) begin
						count_q      <= '0;
						pend_q       <= '0;
						prev_chain_q <= '0;
						prev_num_q   <= '0;
						have_prev_q  <= 1'b0;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_CMP_HEAD;
					end
				end
				S_CMP_HEAD: begin
					idx_q <= '0;
					wr_q  <= '0;
					if (count_q == '0) begin
						state_q <= S_SHED;
					end else if (pend_q != '0) begin
						state_q <= S_CMP_HD;
					end else begin
						fchain_q <= cur_chain_q;
						fnum_q   <= $signed({{3{cur_num_q[15]}}, cur_num_q}) + 19'sd1;
						state_q  <= S_CMP_A;
					end
				end
				S_CMP_HD: begin
					fchain_q <= ram_rdata.chain;
					fnum_q   <= $signed({{3{ram_rdata.num[15]}}, ram_rdata.num});
					state_q  <= S_CMP_A;
				end
				S_CMP_A: begin
					state_q <= S_CMP_D;
				end
				S_CMP_D: begin
					if (keep_now) begin
						wr_q <= wr_q + 1'b1;
					end
					idx_q <= idx_nx;
					if (idx_nx == count_q) begin
						count_q <= wr_q + rsgf_pkg::CNT_W'(keep_now);
						state_q <= S_SHED;
					end else begin
						state_q <= S_CMP_A;
					end
				end
				S_SHED: begin
					idx_q <= rsgf_pkg::CNT_W'(1);
					if (int'(count_q) > rsgf_pkg::SHED_LIMIT) begin
						state_q <= (pend_q >= count_q) ? S_SHED_D : S_DROP_A;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_SHED_D: begin
					e_q        <= ram_rdata;
					ret_shed_q <= 1'b1;
					state_q    <= S_EMIT;
				end
				S_DROP_A: begin
					state_q <= S_DROP_D;
				end
				S_DROP_D: begin
					idx_q <= idx_nx;
					if (idx_nx == count_q) begin
						count_q <= count_q - 1'b1;
						state_q <= S_SHED;
					end else begin
						state_q <= S_DROP_A;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign div_req.start    = div_start_q;
	assign div_req.dividend = div_dvd_q;
	assign div_req.divisor  = div_dvs_q;

	rsgf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rsgf_ram #(
		.WIDTH ($bits(rsgf_pkg::entry_t)),
		.DEPTH (rsgf_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_chain = out_e_q.chain;
	assign first_num = out_e_q.num;
	assign run_len   = out_e_q.len;
	assign kind      = out_e_q.kind;
	assign score     = out_e_q.score;
	assign last_out  = out_last_q;

endmodule

/* rtl/core/rsgf_checker.sv */
// ----------------------------------------------------------------------------
// Residue score smoother port checker
// Checks on the top level's ports, attached to it by a bind statement.
// ----------------------------------------------------------------------------
module rsgf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [7:0]                   out_chain,
	input logic [15:0]                  first_num,
	input logic [15:0]                  run_len,
	input logic [1:0]                   kind,
	input logic [rsgf_pkg::SCORE_W-1:0] score,
	input logic                         last_out
);

	// A stalled result must hold all of its fields.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_chain) && $stable(first_num) &&
		$stable(run_len) && $stable(kind) && $stable(score) && $stable(last_out))
		else $error("stalled result changed");

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != rsgf_pkg::KIND_SCORE) |-> score == '0)
		else $error("score set on a result without value");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != rsgf_pkg::KIND_GAP) |-> run_len == 16'd1)
		else $error("run length above one on a residue result");

endmodule

bind residue_score_gap_fill_window_smoother rsgf_checker u_rsgf_checker (.*);

/* tb/tb_residue_score_gap_fill_window_smoother.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the residue score gap filler and window smoother
// Sorted residue streams with random content and some disorder are driven
// through the block under random idling and stalling, while a local copy of
// the store, gap and window logic predicts every result for comparison.
// ----------------------------------------------------------------------------
module tb_residue_score_gap_fill_window_smoother;

	localparam int LIMIT = 10000000;

	typedef struct packed {
		logic [7:0]  ch;
		logic [15:0] num;
		logic [23:0] ra;
		logic [23:0] da;
		logic        fin;
	} residue_t;

	typedef struct packed {
		logic [7:0]                   ch;
		logic [15:0]                  num;
		logic [15:0]                  len;
		logic [1:0]                   kind;
		logic [rsgf_pkg::SCORE_W-1:0] score;
		logic                         last;
	} result_t;

	typedef struct {
		int chain;
		int num;
		int len;
		int kind;
		int score;
	} slot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [rsgf_pkg::WIN_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] chain = '0;
	logic signed [15:0] residue_num = '0;
	logic [rsgf_pkg::AREA_W-1:0] ref_area = '0;
	logic [rsgf_pkg::AREA_W-1:0] diff_area = '0;
	logic final_item = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] out_chain;
	logic signed [15:0] first_num;
	logic [15:0] run_len;
	logic [1:0] kind;
	logic [rsgf_pkg::SCORE_W-1:0] score;
	logic last_out;

	residue_t residue_q[$];
	result_t result_q[$];
	residue_t cur;
	int idle_pct = 0;
	int stall_pct = 0;
	bit took = 1'b0;
	int errors = 0;
	int cycles = 0;

	slot_t slots[rsgf_pkg::STORE_DEPTH];
	int slot_n = 0;
	int pend_n = 0;
	int last_chain = 0;
	int last_num = 0;
	bit have_last = 1'b0;
	int win_reg = 0;
	result_t step_out[$];

	residue_score_gap_fill_window_smoother dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .chain(chain),
		.residue_num(residue_num), .ref_area(ref_area), .diff_area(diff_area),
		.final_item(final_item), .out_valid(out_valid), .out_stall(out_stall),
		.out_chain(out_chain), .first_num(first_num), .run_len(run_len),
		.kind(kind), .score(score), .last_out(last_out)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (cycles >= LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			cycles <= cycles + 1;
		end
	end

	function automatic bit positive(slot_t s);
		return s.kind == int'(rsgf_pkg::KIND_SCORE) && s.score > 0;
	endfunction

	function automatic int window_mean(int idx, int w);
		int sum;
		int cnt;
		int d;
		sum = 0;
		cnt = 0;
		if (!positive(slots[idx]) || w == 0)
			return slots[idx].score;
		for (int j = 0; j < slot_n; j++) begin
			if (positive(slots[j]) && slots[j].chain == slots[idx].chain) begin
				d = slots[j].num - slots[idx].num;
				if (d >= -w && d <= w) begin
					sum += slots[j].score;
					cnt++;
				end
			end
		end
		return cnt ? sum / cnt : slots[idx].score;
	endfunction

	function automatic bit context_done(int idx, int w, bit fin);
		int hi;
		if (fin || !positive(slots[idx]) || w == 0)
			return 1'b1;
		if (slots[slot_n-1].chain != slots[idx].chain)
			return 1'b1;
		hi = slots[slot_n-1].num + slots[slot_n-1].len - 1;
		return hi >= slots[idx].num + w;
	endfunction

	task automatic release_oldest(int w);
		int idx;
		result_t r;
		idx = slot_n - pend_n;
		r.ch = slots[idx].chain[7:0];
		r.num = slots[idx].num[15:0];
		r.len = slots[idx].len[15:0];
		r.kind = slots[idx].kind[1:0];
		r.score = (slots[idx].kind == int'(rsgf_pkg::KIND_SCORE)) ?
			rsgf_pkg::SCORE_W'(window_mean(idx, w)) : '0;
		r.last = 1'b0;
		step_out.push_back(r);
		pend_n--;
	endtask

	task automatic shed_oldest(int w);
		if (pend_n >= slot_n)
			release_oldest(w);
		for (int i = 0; i < slot_n - 1; i++)
			slots[i] = slots[i+1];
		slot_n--;
	endtask

	task automatic store_slot(slot_t s, int w);
		while (slot_n >= rsgf_pkg::STORE_DEPTH)
			shed_oldest(w);
		slots[slot_n] = s;
		slot_n++;
		pend_n++;
	endtask

	task automatic trim_context(int w);
		int done;
		int wr;
		int fch;
		int fnum;
		bit keep;
		if (slot_n == 0)
			return;
		done = slot_n - pend_n;
		wr = 0;
		if (pend_n > 0) begin
			fch = slots[done].chain;
			fnum = slots[done].num;
		end else begin
			fch = slots[slot_n-1].chain;
			fnum = slots[slot_n-1].num + slots[slot_n-1].len;
		end
		for (int i = 0; i < slot_n; i++) begin
			keep = (i >= done) || (w > 0 && positive(slots[i]) && slots[i].chain == fch
				&& fnum - slots[i].num <= w);
			if (keep) begin
				slots[wr] = slots[i];
				wr++;
			end
		end
		slot_n = wr;
	endtask

	task automatic predict_residue(residue_t it);
		int w;
		int num;
		longint q;
		slot_t s;
		w = (win_reg > rsgf_pkg::MAX_WINDOW) ? rsgf_pkg::MAX_WINDOW : win_reg;
		num = int'($signed(it.num));
		step_out.delete();
		if (have_last && int'(it.ch) == last_chain && num - last_num > 1) begin
			s.chain = int'(it.ch);
			s.num = last_num + 1;
			s.len = num - last_num - 1;
			s.kind = int'(rsgf_pkg::KIND_GAP);
			s.score = 0;
			store_slot(s, w);
		end
		s.chain = int'(it.ch);
		s.num = num;
		s.len = 1;
		if (it.ra == 0) begin
			s.kind = int'(rsgf_pkg::KIND_NOVAL);
			s.score = 0;
		end else begin
			q = (longint'(it.da) << 16) / longint'(it.ra);
			s.kind = int'(rsgf_pkg::KIND_SCORE);
			s.score = (q > longint'(rsgf_pkg::SCORE_MAX)) ? int'(rsgf_pkg::SCORE_MAX) :
				int'(q);
		end
		store_slot(s, w);
		have_last = 1'b1;
		last_chain = int'(it.ch);
		last_num = num;
		while (pend_n > 0 && context_done(slot_n - pend_n, w, it.fin))
			release_oldest(w);
		if (it.fin) begin
			if (step_out.size() > 0)
				step_out[step_out.size()-1].last = 1'b1;
			slot_n = 0;
			pend_n = 0;
			last_chain = 0;
			last_num = 0;
			have_last = 1'b0;
		end else begin
			trim_context(w);
			while (slot_n > rsgf_pkg::STORE_DEPTH - 2)
				shed_oldest(w);
		end
		foreach (step_out[i])
			result_q.push_back(step_out[i]);
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (cfg_we)
			win_reg = int'(cfg_wdata);
		took = in_valid && !in_stall;
		if (took)
			predict_residue({chain, residue_num, ref_area, diff_area, final_item});
		if (out_valid && !out_stall) begin
			got = {out_chain, first_num, run_len, kind, score, last_out};
			if (result_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("Unexpected result: %h", got);
			end else begin
				want = result_q.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display("Mismatch: expected %h actual %h", want, got);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < stall_pct);
			if (!in_valid || took) begin
				if (residue_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					cur = residue_q.pop_front();
					chain <= cur.ch;
					residue_num <= cur.num;
					ref_area <= cur.ra;
					diff_area <= cur.da;
					final_item <= cur.fin;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic add_residue(int ch, int num, int ra, int da, bit fin);
		residue_t it;
		it.ch = 8'(ch);
		it.num = 16'(num);
		it.ra = 24'(ra);
		it.da = 24'(da);
		it.fin = fin;
		residue_q.push_back(it);
	endtask

	task automatic random_area(output int ra, output int da);
		int sel;
		sel = $urandom_range(9);
		ra = (sel == 0) ? 0 : $urandom_range(24'hFFFFFF, 1) >> $urandom_range(23);
		ra = (sel != 0 && ra == 0) ? 1 : ra;
		da = ($urandom_range(9) == 0) ? 0 : $urandom_range(24'hFFFFFF) >> $urandom_range(23);
	endtask

	task automatic add_stream(int n);
		int ch;
		int num;
		int ra;
		int da;
		ch = int'($urandom_range(255));
		num = int'($urandom_range(65535)) - 32768;
		for (int i = 0; i < n; i++) begin
			random_area(ra, da);
			if ($urandom_range(99) < 88) begin
				if ($urandom_range(99) < 8 || num > 32000) begin
					ch = (ch + 1 + int'($urandom_range(3))) % 256;
					num = int'($urandom_range(400)) - 200;
				end else if ($urandom_range(99) < 15) begin
					num += 2 + int'($urandom_range(6));
				end else begin
					num += 1;
				end
				add_residue(ch, num, ra, da, i == n - 1);
			end else begin
				add_residue(int'($urandom_range(255)), int'($urandom_range(65535)), ra, da,
					i == n - 1);
			end
		end
	endtask

	task automatic settle_then_write(int w);
		while (residue_q.size() > 0 || in_valid || result_q.size() > 0)
			@(posedge clk);
		repeat (1500) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= rsgf_pkg::WIN_W'(w);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		add_residue(8'h00, 16'sh8000, 24'h000000, 24'hFFFFFF, 1'b0);
		add_residue(8'h00, 16'sh7FFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
		add_residue(8'h00, 16'sh7FFF, 24'h000001, 24'hFFFFFF, 1'b0);
		add_residue(8'h00, 16'sh7FF0, 24'h000100, 24'h000000, 1'b0);
		add_residue(8'hFF, 5, 24'h000200, 24'h000100, 1'b0);
		add_residue(8'hFF, 9, 24'h000100, 24'h000300, 1'b0);
		add_residue(8'hFF, 10, 24'h000000, 24'h000000, 1'b1);
		while (residue_q.size() > 0 || in_valid || result_q.size() > 0)
			@(posedge clk);
		add_stream(20);

		settle_then_write(rsgf_pkg::MAX_WINDOW);
		add_residue(8'h41, 1, 24'h000100, 24'h000080, 1'b0);
		add_residue(8'h41, 2, 24'h000100, 24'h000040, 1'b0);
		add_residue(8'h41, 3, 24'h000000, 24'h000040, 1'b0);
		add_residue(8'h41, 6, 24'h000100, 24'h000000, 1'b0);
		add_residue(8'h41, 7, 24'h000001, 24'hFFFFFF, 1'b0);
		add_residue(8'h41, 30, 24'h000100, 24'h000100, 1'b0);
		add_residue(8'h42, 30, 24'h000100, 24'h000200, 1'b0);
		add_residue(8'h42, 28, 24'h000100, 24'h000300, 1'b0);
		add_residue(8'h42, 28, 24'h000100, 24'h000300, 1'b1);
		add_stream(60);

		idle_pct = 75;
		settle_then_write(1);
		add_stream(50);

		idle_pct = 0;
		stall_pct = 75;
		settle_then_write(31);
		add_stream(70);

		idle_pct = 27;
		stall_pct = 27;
		settle_then_write(0);
		add_stream(30);

		settle_then_write(int'($urandom_range(15, 2)));
		add_stream(35);

		while (residue_q.size() > 0 || in_valid || result_q.size() > 0)
			@(posedge clk);
		repeat (1500) @(posedge clk);
		if (errors == 0 && result_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
